@@ design/dmx_rx_pkg.sv @@
// Shared types and constants for the DMX512 receive framer.
// No dependencies; imported by dmx512_frame_receiver.
`timescale 1ns / 1ps
`default_nettype none

package dmx_rx_pkg;

	localparam int SLOTS_DEFAULT = 513;

	// Beat layout
	localparam int TDATA_W  = 24;
	localparam int S_TUSER_W = 4;
	localparam int M_TUSER_W = 1;
	localparam int IDX_W    = 10;
	localparam int IDX_EXT_W = 11;  // wide enough to hold SLOTS values up to 2047
	localparam int CNT_OUT_W = 10;
	localparam int US_W     = 20;

	localparam logic [US_W-1:0] LOW_TIME_MAX      = 20'hFFFFF;
	localparam logic [US_W-1:0] BREAK_MIN_DEFAULT = 20'd88;
	localparam logic [US_W-1:0] BREAK_MAX_DEFAULT = 20'd1000000;

	// Operation codes carried in s_tuser[2:0]
	localparam logic [2:0] OP_TICK = 3'd0;
	localparam logic [2:0] OP_FALL = 3'd1;
	localparam logic [2:0] OP_RISE = 3'd2;
	localparam logic [2:0] OP_BYTE = 3'd3;
	localparam logic [2:0] OP_READ = 3'd4;

	// Configuration register indexes
	localparam logic REG_BREAK_MIN = 1'b0;
	localparam logic REG_BREAK_MAX = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_COPY,
		ST_DRAIN
	} state_t;

endpackage

`default_nettype wire

@@ design/dmx512_frame_receiver.sv @@
// DMX512 receive framer: receive store, frame store and the control around them.
// Depends on dmx_rx_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Takes one event per input beat (microsecond tick, line fall, line rise, received
// byte, slot read) and returns exactly one result beat for each. Ticks, edges and
// bytes give their result in the cycle after acceptance; a slot read passes first
// through the registered read of the frame store. A rise that ends a valid break
// with n slots held copies them from the receive store to the frame store, one slot
// per cycle through the receive store read port, in ST_COPY and then ST_DRAIN (with
// n zero nothing is copied). No input beat is taken while a read or a copy is in
// progress; a new beat is taken while the previous result is being handed off. The
// frame store needs no clearing pass after reset: a high-water mark of copied slots
// makes any slot never written read as zero.
module dmx512_frame_receiver
	import dmx_rx_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEFAULT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// input beats
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [TDATA_W-1:0]    s_tdata,   // rx_byte[7:0], slot_index[17:8], zero
	input  wire logic [S_TUSER_W-1:0]  s_tuser,   // operation[2:0], rx_error[3]
	// result beats
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [TDATA_W-1:0]         m_tdata,   // slot_data[7:0], slots_copied[17:8], zero
	output logic [M_TUSER_W-1:0]       m_tuser,   // frame_ready[0]
	// configuration writes
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic                  cfg_index,
	input  wire logic [US_W-1:0]       cfg_data
);

	localparam int AW    = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam logic [IDX_EXT_W-1:0] SLOTS_EXT = IDX_EXT_W'(SLOTS);
	localparam logic [CNT_W-1:0]     SLOTS_CNT = CNT_W'(SLOTS);

	// Input fields
	logic [2:0]       op;
	logic             rx_error;
	logic [7:0]       rx_byte;
	logic [IDX_W-1:0] slot_index;

	assign op         = s_tuser[2:0];
	assign rx_error   = s_tuser[3];
	assign rx_byte    = s_tdata[7:0];
	assign slot_index = s_tdata[17:8];

	// State
	state_t           state_q, state_d;
	logic [US_W-1:0]  brk_min_q, brk_max_q;
	logic [US_W-1:0]  low_q;
	logic [CNT_W-1:0] slot_cnt_q;
	logic [CNT_W-1:0] fill_q;     // slots of the frame store ever written
	logic [CNT_W-1:0] cp_n_q, cp_rd_q;
	logic             cp_valid_s1;
	logic [AW-1:0]    cp_addr_s1;
	logic             rd_hit_s1;

	// Memories
	logic [7:0] recv_mem  [SLOTS];
	logic [7:0] frame_mem [SLOTS];
	logic [7:0] recv_rdata_q, frame_rdata_q;

	// Result register
	logic                 m_tvalid_q;
	logic                 frame_ready_q;
	logic [7:0]           slot_data_q;
	logic [CNT_OUT_W-1:0] slots_copied_q;

	// Control
	logic                 accept, out_free, in_window, idx_hit;
	logic                 recv_we, frame_re, cp_issue, start_copy;
	logic                 res_load, res_ready;
	logic [7:0]           res_data;
	logic [CNT_OUT_W-1:0] res_copied;

	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign in_window = (low_q >= brk_min_q) && (low_q <= brk_max_q);
	assign idx_hit   = ({1'b0, slot_index} < SLOTS_EXT) &&
	                   ({1'b0, slot_index} < IDX_EXT_W'(fill_q));
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		recv_we    = 1'b0;
		frame_re   = 1'b0;
		cp_issue   = 1'b0;
		start_copy = 1'b0;
		res_load   = 1'b0;
		res_ready  = 1'b0;
		res_data   = 8'd0;
		res_copied = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = out_free;
				if (accept) begin
					case (op)
						OP_RISE: begin
							if (in_window && slot_cnt_q != '0) begin
								start_copy = 1'b1;
								state_d    = ST_COPY;
							end else begin
								res_load  = 1'b1;
								res_ready = in_window;
							end
						end
						OP_BYTE: begin
							recv_we  = !rx_error && (slot_cnt_q < SLOTS_CNT);
							res_load = 1'b1;
						end
						OP_READ: begin
							frame_re = 1'b1;
							state_d  = ST_READ;
						end
						default: begin
							res_load = 1'b1;
						end
					endcase
				end
			end
			ST_READ: begin
				res_load = 1'b1;
				res_data = rd_hit_s1 ? frame_rdata_q : 8'd0;
				state_d  = ST_IDLE;
			end
			ST_COPY: begin
				cp_issue = 1'b1;
				if (cp_rd_q == cp_n_q - CNT_W'(1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// last slot lands in the frame store this cycle
				res_load   = 1'b1;
				res_ready  = 1'b1;
				res_copied = CNT_OUT_W'(cp_n_q);
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brk_min_q   <= BREAK_MIN_DEFAULT;
			brk_max_q   <= BREAK_MAX_DEFAULT;
			low_q       <= '0;
			slot_cnt_q  <= '0;
			fill_q      <= '0;
			cp_n_q      <= '0;
			cp_rd_q     <= '0;
			cp_valid_s1 <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_BREAK_MIN: brk_min_q <= cfg_data;
					REG_BREAK_MAX: brk_max_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept && op == OP_TICK && low_q != LOW_TIME_MAX) begin
				low_q <= low_q + US_W'(1);
			end else if (accept && op == OP_FALL) begin
				low_q <= '0;
			end
			if (recv_we) begin
				slot_cnt_q <= slot_cnt_q + CNT_W'(1);
			end else if (start_copy) begin
				slot_cnt_q <= '0;
			end
			if (start_copy) begin
				cp_n_q  <= slot_cnt_q;
				cp_rd_q <= '0;
				if (slot_cnt_q > fill_q) begin
					fill_q <= slot_cnt_q;
				end
			end else if (cp_issue) begin
				cp_rd_q <= cp_rd_q + CNT_W'(1);
			end
			cp_valid_s1 <= cp_issue;
			if (res_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		cp_addr_s1 <= cp_rd_q[AW-1:0];
		if (frame_re) begin
			rd_hit_s1 <= idx_hit;
		end
		if (res_load) begin
			frame_ready_q  <= res_ready;
			slot_data_q    <= res_data;
			slots_copied_q <= res_copied;
		end
	end

	// Receive store: written by good bytes, read by the copy loop
	always_ff @(posedge clk) begin
		if (recv_we) begin
			recv_mem[slot_cnt_q[AW-1:0]] <= rx_byte;
		end
		if (cp_issue) begin
			recv_rdata_q <= recv_mem[cp_rd_q[AW-1:0]];
		end
	end

	// Frame store: written by the copy loop, read by slot reads
	always_ff @(posedge clk) begin
		if (cp_valid_s1) begin
			frame_mem[cp_addr_s1] <= recv_rdata_q;
		end
		if (frame_re) begin
			frame_rdata_q <= frame_mem[slot_index[AW-1:0]];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, slots_copied_q, slot_data_q};
	assign m_tuser  = frame_ready_q;

	// Input is held off while a read or copy owns the memories
	a_busy_no_input: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !s_tready)
		else $error("input taken while busy");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		slot_cnt_q <= SLOTS_CNT && fill_q <= SLOTS_CNT)
		else $error("slot count beyond store depth");

	a_copy_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COPY |-> cp_rd_q < cp_n_q)
		else $error("copy read past slot count");

	a_copy_below_fill: assert property (@(posedge clk) disable iff (!arst_n)
		cp_valid_s1 |-> CNT_W'(cp_addr_s1) < fill_q)
		else $error("frame write above high-water mark");

	a_result_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ || state_q == ST_DRAIN) |-> !m_tvalid_q)
		else $error("result register overwritten");

endmodule

`default_nettype wire
